[design/s2a_pkg.sv]
package s2a_pkg;

    localparam int TABLE_ENTRIES = 88;
    localparam int TAB_ROWS      = 56;

    localparam logic [7:0] SC_PREFIX      = 8'hE0;
    localparam logic [7:0] SC_LSHIFT_MAKE = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE = 8'h36;
    localparam logic [7:0] SC_LSHIFT_REL  = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_REL  = 8'hB6;
    localparam logic [7:0] SC_CTRL_MAKE   = 8'h1D;
    localparam logic [7:0] SC_CTRL_REL    = 8'h9D;
    localparam logic [7:0] SC_KEY_L       = 8'h26;
    localparam logic [7:0] SC_KEY_A       = 8'h1E;
    localparam logic [7:0] SC_KEY_E       = 8'h12;
    localparam logic [7:0] SC_KEY_U       = 8'h16;
    localparam logic [7:0] SC_BACKSPACE   = 8'h0E;
    localparam logic [7:0] SC_TAB         = 8'h0F;
    localparam logic [7:0] SC_ENTER       = 8'h1C;
    localparam logic [7:0] SC_SPACE       = 8'h39;
    localparam logic [7:0] SC_UP          = 8'h48;
    localparam logic [7:0] SC_DOWN        = 8'h50;
    localparam logic [7:0] SC_LEFT        = 8'h4B;
    localparam logic [7:0] SC_RIGHT       = 8'h4D;
    localparam logic [7:0] SC_HOME        = 8'h47;
    localparam logic [7:0] SC_END         = 8'h4F;
    localparam logic [7:0] SC_DELETE      = 8'h53;
    localparam logic [7:0] SC_PAGE_UP     = 8'h49;
    localparam logic [7:0] SC_PAGE_DOWN   = 8'h51;

    localparam logic [6:0] CH_NONE  = 7'h00;
    localparam logic [6:0] CH_ESC   = 7'h1B;
    localparam logic [6:0] CH_BS    = 7'h08;
    localparam logic [6:0] CH_TAB   = 7'h09;
    localparam logic [6:0] CH_LF    = 7'h0A;
    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_LOW_L = 7'h6C;
    localparam logic [6:0] CH_CTL_A = 7'h01;
    localparam logic [6:0] CH_CTL_E = 7'h05;
    localparam logic [6:0] CH_CTL_U = 7'h15;
    localparam logic [6:0] EXT_CLEAR = 7'h03;

    typedef struct packed {
        logic       esc;
        logic [6:0] code;
    } t_job;

    localparam logic [6:0] US_BASE [TAB_ROWS] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h00, 7'h00,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h00, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A
    };

    localparam logic [6:0] US_SHIFT [TAB_ROWS] = '{
        7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h00, 7'h00,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h00, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A
    };

    localparam logic [6:0] LA_BASE [TAB_ROWS] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h27, 7'h00, 7'h00, 7'h00,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h27, 7'h2B, 7'h00, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h7C, 7'h00, 7'h7D, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2D, 7'h00, 7'h2A
    };

    localparam logic [6:0] LA_SHIFT [TAB_ROWS] = '{
        7'h00, 7'h00, 7'h21, 7'h22, 7'h23, 7'h24, 7'h25, 7'h26,
        7'h2F, 7'h28, 7'h29, 7'h3D, 7'h3F, 7'h21, 7'h00, 7'h00,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h22, 7'h2A, 7'h00, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h5F, 7'h00, 7'h2A
    };

    function automatic logic [6:0] f_table(input logic layout, input logic shift,
                                           input logic [7:0] sc);
        logic [5:0] idx;
        logic [6:0] ch;
        idx = sc[5:0];
        ch  = CH_NONE;
        if ((32'(sc) < TABLE_ENTRIES) && (32'(sc) < TAB_ROWS)) begin
            case ({layout, shift})
                2'b00:   ch = US_BASE[idx];
                2'b01:   ch = US_SHIFT[idx];
                2'b10:   ch = LA_BASE[idx];
                default: ch = LA_SHIFT[idx];
            endcase
        end
        return ch;
    endfunction

    function automatic logic [6:0] f_ext_code(input logic [7:0] sc);
        logic [6:0] c;
        case (sc)
            SC_UP:        c = 7'h04;
            SC_DOWN:      c = 7'h05;
            SC_LEFT:      c = 7'h06;
            SC_RIGHT:     c = 7'h07;
            SC_HOME:      c = 7'h08;
            SC_END:       c = 7'h09;
            SC_DELETE:    c = 7'h0A;
            SC_PAGE_UP:   c = 7'h01;
            SC_PAGE_DOWN: c = 7'h02;
            default:      c = CH_NONE;
        endcase
        return c;
    endfunction

endpackage

[design/scancode_to_ascii_decoder.sv]
// Channel   Valid     Stall     Payload
// input     i_valid   o_stall   i_scancode
// output    o_valid   i_stall   o_char_byte, o_last_of_run
// config    i_layout_select_we  i_layout_select
//
// A scancode is classified in the cycle of its transfer and its job enters a two-entry queue.
// The output register sends one byte a cycle unless the receiver stalls, so an escape pair
// is sent as two bytes and any other key as one; a scancode yielding nothing queues no job.
// The first byte passes the queue memory and then the output register before it appears.
// Reset is synchronous and clears the flags, layout choice, queue count and output valid.
// Input stalls only while the queue is full; output stalls hold the byte in place.
module scancode_to_ascii_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_scancode,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [6:0] o_char_byte,
    output logic       o_last_of_run,
    input  logic       i_layout_select_we,
    input  logic       i_layout_select
);
    import s2a_pkg::*;

    logic full, empty, push, pop, accept;
    t_job front_job, queue_job;

    assign o_stall = full;
    assign accept  = i_valid && !full;

    s2a_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (accept),
        .i_scancode         (i_scancode),
        .i_layout_select_we (i_layout_select_we),
        .i_layout_select    (i_layout_select),
        .o_push             (push),
        .o_job              (front_job)
    );

    s2a_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (queue_job)
    );

    s2a_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_job         (queue_job),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_char_byte   (o_char_byte),
        .o_last_of_run (o_last_of_run)
    );

endmodule

[design/s2a_front.sv]
module s2a_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_scancode,
    input  logic          i_layout_select_we,
    input  logic          i_layout_select,
    output logic          o_push,
    output s2a_pkg::t_job o_job
);
    import s2a_pkg::*;

    logic r_layout, r_prefix, r_shift, r_ctrl;
    logic n_prefix, n_shift, n_ctrl;
    t_job job;

    always_comb begin
        n_prefix = r_prefix;
        n_shift  = r_shift;
        n_ctrl   = r_ctrl;
        job      = '{esc: 1'b0, code: CH_NONE};
        if (i_scancode == SC_PREFIX) begin
            n_prefix = 1'b1;
        end else if (r_prefix) begin
            n_prefix = 1'b0;
            if (!i_scancode[7]) begin
                job = '{esc: 1'b1, code: f_ext_code(i_scancode)};
            end
        end else begin
            if (i_scancode == SC_LSHIFT_MAKE || i_scancode == SC_RSHIFT_MAKE) begin
                n_shift = 1'b1;
            end else if (i_scancode == SC_LSHIFT_REL || i_scancode == SC_RSHIFT_REL) begin
                n_shift = 1'b0;
            end else if (i_scancode == SC_CTRL_REL) begin
                n_ctrl = 1'b0;
            end
            if (!i_scancode[7]) begin
                case (i_scancode)
                    SC_BACKSPACE: job.code = CH_BS;
                    SC_TAB:       job.code = CH_TAB;
                    SC_ENTER:     job.code = CH_LF;
                    SC_SPACE:     job.code = CH_SPACE;
                    SC_CTRL_MAKE: n_ctrl = 1'b1;
                    SC_KEY_L: begin
                        if (r_ctrl) begin
                            n_ctrl = 1'b0;
                            job    = '{esc: 1'b1, code: EXT_CLEAR};
                        end else begin
                            job.code = CH_LOW_L;
                        end
                    end
                    SC_KEY_A: job.code = r_ctrl ? CH_CTL_A
                                                : f_table(r_layout, r_shift, i_scancode);
                    SC_KEY_E: job.code = r_ctrl ? CH_CTL_E
                                                : f_table(r_layout, r_shift, i_scancode);
                    SC_KEY_U: job.code = r_ctrl ? CH_CTL_U
                                                : f_table(r_layout, r_shift, i_scancode);
                    default:  job.code = f_table(r_layout, r_shift, i_scancode);
                endcase
            end
        end
    end

    assign o_push = i_valid && (job.code != CH_NONE);
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout <= 1'b0;
            r_prefix <= 1'b0;
            r_shift  <= 1'b0;
            r_ctrl   <= 1'b0;
        end else begin
            if (i_layout_select_we) begin
                r_layout <= i_layout_select;
            end
            if (i_valid) begin
                r_prefix <= n_prefix;
                r_shift  <= n_shift;
                r_ctrl   <= n_ctrl;
            end
        end
    end

endmodule

[design/s2a_queue.sv]
module s2a_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  s2a_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output s2a_pkg::t_job o_job
);
    import s2a_pkg::*;

    t_job       r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[design/s2a_back.sv]
module s2a_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  s2a_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [6:0]    o_char_byte,
    output logic          o_last_of_run
);
    import s2a_pkg::*;

    logic       r_valid, r_pend;
    logic [6:0] r_char, r_pend_code;
    logic       r_last;
    logic       load;

    assign load  = !r_valid || !i_stall;
    assign o_pop = load && !r_pend && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (load) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else begin
                r_valid <= !i_empty;
                r_pend  <= !i_empty && i_job.esc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_pend) begin
                r_char <= r_pend_code;
                r_last <= 1'b1;
            end else begin
                r_char      <= i_job.esc ? CH_ESC : i_job.code;
                r_last      <= !i_job.esc;
                r_pend_code <= i_job.code;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_char_byte   = r_char;
    assign o_last_of_run = r_last;

endmodule

[design/s2a_checker.sv]
module s2a_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [7:0] i_scancode,
    input logic       o_valid,
    input logic       i_stall,
    input logic [6:0] o_char_byte,
    input logic       o_last_of_run,
    input logic       i_layout_select_we,
    input logic       i_layout_select
);
    import s2a_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_char_byte) && $stable(o_last_of_run))
        else $error("output changed while stalled");

    a_lead_esc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_of_run |-> o_char_byte == CH_ESC)
        else $error("leading byte of a pair is not ESC");

    a_pair_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_of_run |=> o_valid && o_last_of_run)
        else $error("second byte of a pair did not follow");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output or stall active after reset");

endmodule

bind scancode_to_ascii_decoder s2a_checker u_s2a_checker (.*);

[tb/sv/tb_scancode_to_ascii_decoder.sv]
module tb_scancode_to_ascii_decoder;
    import s2a_pkg::*;

    typedef struct packed {
        bit [6:0] ch;
        bit       last;
    } t_char;

    localparam bit [6:0] NAV_PG_UP = 7'h01;
    localparam bit [6:0] NAV_PG_DN = 7'h02;
    localparam bit [6:0] NAV_UP    = 7'h04;
    localparam bit [6:0] NAV_DN    = 7'h05;
    localparam bit [6:0] NAV_LT    = 7'h06;
    localparam bit [6:0] NAV_RT    = 7'h07;
    localparam bit [6:0] NAV_START = 7'h08;
    localparam bit [6:0] NAV_STOP  = 7'h09;
    localparam bit [6:0] NAV_DEL   = 7'h0A;

    localparam int MAP_ROWS = 56;

    localparam bit [7:0] map_us_plain [MAP_ROWS] = '{
        8'h00, 8'h00, "1", "2", "3", "4", "5", "6",
        "7", "8", "9", "0", "-", "=", 8'h00, 8'h00,
        "q", "w", "e", "r", "t", "y", "u", "i",
        "o", "p", "[", "]", 8'h00, 8'h00, "a", "s",
        "d", "f", "g", "h", "j", "k", "l", ";",
        "'", 8'h60, 8'h00, 8'h5C, "z", "x", "c", "v",
        "b", "n", "m", ",", ".", "/", 8'h00, "*"
    };

    localparam bit [7:0] map_us_shifted [MAP_ROWS] = '{
        8'h00, 8'h00, "!", "@", "#", "$", "%", "^",
        "&", "*", "(", ")", "_", "+", 8'h00, 8'h00,
        "Q", "W", "E", "R", "T", "Y", "U", "I",
        "O", "P", "{", "}", 8'h00, 8'h00, "A", "S",
        "D", "F", "G", "H", "J", "K", "L", ":",
        8'h22, "~", 8'h00, "|", "Z", "X", "C", "V",
        "B", "N", "M", "<", ">", "?", 8'h00, "*"
    };

    localparam bit [7:0] map_la_plain [MAP_ROWS] = '{
        8'h00, 8'h00, "1", "2", "3", "4", "5", "6",
        "7", "8", "9", "0", "'", 8'h00, 8'h00, 8'h00,
        "q", "w", "e", "r", "t", "y", "u", "i",
        "o", "p", "'", "+", 8'h00, 8'h00, "a", "s",
        "d", "f", "g", "h", "j", "k", "l", ";",
        "'", "|", 8'h00, "}", "z", "x", "c", "v",
        "b", "n", "m", ",", ".", "-", 8'h00, "*"
    };

    localparam bit [7:0] map_la_shifted [MAP_ROWS] = '{
        8'h00, 8'h00, "!", 8'h22, "#", "$", "%", "&",
        "/", "(", ")", "=", "?", "!", 8'h00, 8'h00,
        "Q", "W", "E", "R", "T", "Y", "U", "I",
        "O", "P", 8'h22, "*", 8'h00, 8'h00, "A", "S",
        "D", "F", "G", "H", "J", "K", "L", ":",
        8'h22, "~", 8'h00, "|", "Z", "X", "C", "V",
        "B", "N", "M", "<", ">", "_", 8'h00, "*"
    };

    localparam bit [7:0] cursor_keys [9] = '{
        SC_UP, SC_DOWN, SC_LEFT, SC_RIGHT, SC_HOME,
        SC_END, SC_DELETE, SC_PAGE_UP, SC_PAGE_DOWN
    };
    localparam bit [7:0] ctrl_keys [4] = '{SC_KEY_A, SC_KEY_E, SC_KEY_U, SC_KEY_L};
    localparam bit [7:0] fixed_keys [4] = '{SC_BACKSPACE, SC_TAB, SC_ENTER, SC_SPACE};
    localparam bit [7:0] shift_codes [4] = '{
        SC_LSHIFT_MAKE, SC_RSHIFT_MAKE, SC_LSHIFT_REL, SC_RSHIFT_REL
    };

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_scancode;
    logic       o_valid;
    logic       i_stall;
    logic [6:0] o_char_byte;
    logic       o_last_of_run;
    logic       i_layout_select_we;
    logic       i_layout_select;

    t_char expected_chars [$];
    int    mismatch_count = 0;

    bit prefix_pending = 1'b0;
    bit shift_on       = 1'b0;
    bit ctrl_on        = 1'b0;
    bit layout_la      = 1'b0;

    bit tx_random = 1'b0;
    bit rx_random = 1'b0;
    int rx_hold   = 0;
    int rx_burst  = 0;

    scancode_to_ascii_decoder dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_scancode         (i_scancode),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_char_byte        (o_char_byte),
        .o_last_of_run      (o_last_of_run),
        .i_layout_select_we (i_layout_select_we),
        .i_layout_select    (i_layout_select)
    );

    always #2 i_clk = ~i_clk;

    function automatic bit [6:0] keymap_char(input bit [7:0] sc);
        bit [7:0] entry;
        entry = 8'h00;
        if (sc < MAP_ROWS) begin
            case ({layout_la, shift_on})
                2'b00:   entry = map_us_plain[sc];
                2'b01:   entry = map_us_shifted[sc];
                2'b10:   entry = map_la_plain[sc];
                default: entry = map_la_shifted[sc];
            endcase
        end
        return entry[6:0];
    endfunction

    function void push_escape(input bit [6:0] code);
        expected_chars.push_back('{ch: CH_ESC, last: 1'b0});
        expected_chars.push_back('{ch: code, last: 1'b1});
    endfunction

    // Updates the keyboard flags for one accepted scancode and queues the bytes it yields.
    function void decode_scancode(input bit [7:0] sc);
        bit [6:0] ch;
        bit [6:0] ext;
        ch = CH_NONE;
        if (sc == SC_PREFIX) begin
            prefix_pending = 1'b1;
            return;
        end
        if (prefix_pending) begin
            prefix_pending = 1'b0;
            if (sc[7]) begin
                return;
            end
            case (sc)
                SC_UP:        ext = NAV_UP;
                SC_DOWN:      ext = NAV_DN;
                SC_LEFT:      ext = NAV_LT;
                SC_RIGHT:     ext = NAV_RT;
                SC_HOME:      ext = NAV_START;
                SC_END:       ext = NAV_STOP;
                SC_DELETE:    ext = NAV_DEL;
                SC_PAGE_UP:   ext = NAV_PG_UP;
                SC_PAGE_DOWN: ext = NAV_PG_DN;
                default:      ext = CH_NONE;
            endcase
            if (ext != CH_NONE) begin
                push_escape(ext);
            end
            return;
        end
        if (sc == SC_LSHIFT_MAKE || sc == SC_RSHIFT_MAKE) begin
            shift_on = 1'b1;
        end else if (sc == SC_LSHIFT_REL || sc == SC_RSHIFT_REL) begin
            shift_on = 1'b0;
        end else if (sc == SC_CTRL_REL) begin
            ctrl_on = 1'b0;
        end
        if (sc[7]) begin
            return;
        end
        case (sc)
            SC_BACKSPACE: ch = CH_BS;
            SC_TAB:       ch = CH_TAB;
            SC_ENTER:     ch = CH_LF;
            SC_SPACE:     ch = CH_SPACE;
            SC_CTRL_MAKE: ctrl_on = 1'b1;
            SC_KEY_L: begin
                if (ctrl_on) begin
                    ctrl_on = 1'b0;
                    push_escape(EXT_CLEAR);
                    return;
                end
                ch = CH_LOW_L;
            end
            SC_KEY_A: ch = ctrl_on ? CH_CTL_A : keymap_char(sc);
            SC_KEY_E: ch = ctrl_on ? CH_CTL_E : keymap_char(sc);
            SC_KEY_U: ch = ctrl_on ? CH_CTL_U : keymap_char(sc);
            default:  ch = keymap_char(sc);
        endcase
        if (ch != CH_NONE) begin
            expected_chars.push_back('{ch: ch, last: 1'b1});
        end
    endfunction

    task automatic send_scancode(input bit [7:0] sc);
        int gap;
        if (tx_random && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            repeat (gap) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_valid    <= 1'b1;
        i_scancode <= sc;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        decode_scancode(sc);
    endtask

    // The extra cycles leave the block idle before anything else is changed.
    task automatic settle_outputs();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_chars.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic select_layout(input bit la);
        settle_outputs();
        i_layout_select_we <= 1'b1;
        i_layout_select    <= la;
        @(negedge i_clk);
        i_layout_select_we <= 1'b0;
        i_layout_select    <= 1'($urandom_range(0, 1));
        layout_la = la;
    endtask

    task automatic type_random(input int count);
        int sent;
        int pick;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                send_scancode(8'($urandom_range(0, 8'h57)));
                sent += 1;
            end else if (pick < 45) begin
                send_scancode(shift_codes[$urandom_range(0, 3)]);
                sent += 1;
            end else if (pick < 57) begin
                send_scancode(SC_CTRL_MAKE);
                send_scancode(ctrl_keys[$urandom_range(0, 3)]);
                sent += 2;
                if ($urandom_range(0, 2) == 0) begin
                    send_scancode(SC_CTRL_REL);
                    sent += 1;
                end
            end else if (pick < 72) begin
                send_scancode(SC_PREFIX);
                send_scancode(cursor_keys[$urandom_range(0, 8)] |
                              ($urandom_range(0, 7) == 0 ? 8'h80 : 8'h00));
                sent += 2;
            end else if (pick < 80) begin
                send_scancode(fixed_keys[$urandom_range(0, 3)]);
                sent += 1;
            end else if (pick < 85) begin
                send_scancode(SC_PREFIX);
                send_scancode(8'($urandom_range(0, 255)));
                sent += 2;
            end else begin
                send_scancode(8'($urandom_range(0, 255)));
                sent += 1;
            end
        end
    endtask

    task automatic test_fixed_keys_and_modifiers();
        bit [7:0] seq [$];
        seq = '{8'h00, 8'h7F, 8'hFF, SC_BACKSPACE, SC_TAB, SC_ENTER, SC_SPACE,
                SC_LSHIFT_MAKE, 8'h02, SC_KEY_L, SC_LSHIFT_REL,
                SC_RSHIFT_MAKE, 8'h0D, SC_RSHIFT_REL,
                SC_CTRL_MAKE, SC_KEY_A, SC_KEY_E, SC_KEY_U, SC_KEY_L, SC_KEY_L,
                SC_CTRL_MAKE, SC_CTRL_REL, SC_KEY_A};
        foreach (seq[i]) begin
            send_scancode(seq[i]);
        end
    endtask

    task automatic test_prefix_handling();
        bit [7:0] seq [$];
        seq = '{SC_PREFIX, SC_PREFIX, SC_UP, SC_PREFIX, SC_UP | 8'h80,
                SC_PREFIX, SC_LSHIFT_MAKE, 8'h02};
        foreach (seq[i]) begin
            send_scancode(seq[i]);
        end
    endtask

    task automatic test_layout_tables();
        bit [7:0] seq [$];
        seq = '{8'h0C, 8'h0D, SC_LSHIFT_MAKE, 8'h0D, 8'h35, SC_LSHIFT_REL};
        select_layout(1'b1);
        foreach (seq[i]) begin
            send_scancode(seq[i]);
        end
        select_layout(1'b0);
    endtask

    task automatic test_random_typing();
        bit la_order [6] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
        foreach (la_order[i]) begin
            select_layout(la_order[i]);
            type_random(120);
        end
    endtask

    // The receiver holds off while the sender keeps offering, so the block must stall its input.
    task automatic test_output_backpressure();
        settle_outputs();
        tx_random = 1'b0;
        rx_hold   = 120;
        repeat (20) begin
            send_scancode(8'($urandom_range(8'h10, 8'h19)));
        end
        send_scancode(SC_PREFIX);
        send_scancode(SC_DOWN);
        send_scancode(SC_PREFIX);
        send_scancode(SC_PAGE_UP);
        settle_outputs();
        tx_random = 1'b1;
    endtask

    task automatic test_sustained_stream();
        select_layout(1'b1);
        tx_random = 1'b0;
        rx_random = 1'b0;
        type_random(120);
    endtask

    task automatic note_mismatch(input string what, input t_char want);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%s: expected char 0x%02h last %0d, got char 0x%02h last %0d",
                     what, want.ch, want.last, o_char_byte, o_last_of_run);
        end
    endtask

    always @(posedge i_clk) begin
        t_char want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (expected_chars.size() == 0) begin
                note_mismatch("Unexpected output transfer", '{ch: CH_NONE, last: 1'b0});
            end else begin
                want = expected_chars.pop_front();
                if (o_char_byte !== want.ch || o_last_of_run !== want.last) begin
                    note_mismatch("Output mismatch", want);
                end
            end
        end
    end

    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                i_stall <= 1'b1;
                rx_hold--;
            end else if (rx_burst > 0) begin
                i_stall <= 1'b1;
                rx_burst--;
            end else if (rx_random && $urandom_range(0, 9) == 0) begin
                i_stall  <= 1'b1;
                rx_burst = $urandom_range(1, 19) - 1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        #2000000;
        $display("tb_scancode_to_ascii_decoder: FAIL");
        $finish;
    end

    initial begin
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        i_valid            = 1'b0;
        i_scancode         = 8'h00;
        i_layout_select_we = 1'b0;
        i_layout_select    = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        tx_random = 1'b1;
        rx_random = 1'b1;

        test_fixed_keys_and_modifiers();
        test_prefix_handling();
        test_layout_tables();
        test_random_typing();
        test_output_backpressure();
        test_sustained_stream();

        settle_outputs();
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0 && expected_chars.size() == 0) begin
            $display("tb_scancode_to_ascii_decoder: PASS");
        end else begin
            $display("tb_scancode_to_ascii_decoder: FAIL");
        end
        $finish;
    end
endmodule

[filelist.f]
design/s2a_pkg.sv
design/s2a_front.sv
design/s2a_queue.sv
design/s2a_back.sv
design/scancode_to_ascii_decoder.sv
design/s2a_checker.sv
tb/sv/tb_scancode_to_ascii_decoder.sv
